FILE: rtl/core/etmb_pkg.sv
// shared constants, types and helper functions of the transform matrix builder
package etmb_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int STEP_W       = $clog2(TABLE_LEN);
  localparam int DIV_W        = 33;
  localparam int ANG_W        = 36;
  localparam int CW           = 34;
  localparam int ANG_SHIFT    = 18;

  localparam logic signed [ANG_W-1:0] TWO_PI   = 36'sd6746518852;
  localparam logic signed [ANG_W-1:0] PI       = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] NEG_PI   = -36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI  = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0] NEG_HALF_PI = -36'sd1686629713;
  localparam logic signed [CW-1:0]    GAIN     = 34'sd652032874;

  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic signed [31:0] Q16_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;

  localparam logic [1:0] COL_MOVE        = 2'd3;
  localparam logic [1:0] COL_LAST_NORMAL = 2'd2;

  typedef logic signed [15:0]      q12_t;
  typedef logic signed [31:0]      q16_t;
  typedef logic signed [31:0]      q30_t;
  typedef logic signed [33:0]      rot_t;
  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [CW-1:0]    cw_t;
  typedef logic [DIV_W-1:0]        div_t;

  // lane 0 carries rot_y, lane 1 rot_x, lane 2 rot_z
  typedef struct packed {
    logic         func;
    q12_t [2:0]   rot;
    q16_t [2:0]   scale;
    q16_t [2:0]   move;
  } in_t;

  typedef struct packed {
    logic         func;
    q16_t [2:0]   scale;
    q16_t [2:0]   move;
    logic [2:0]   s_neg;
    logic [2:0]   s_zero;
    logic [2:0]   flip;
    cw_t  [2:0]   cx;
    cw_t  [2:0]   cy;
    ang_t [2:0]   cz;
    logic [2:0][31:0] dm;
    div_t [2:0]   drem;
    div_t [2:0]   dnum;
    div_t [2:0]   dquo;
  } pipe_t;

  typedef q16_t [2:0] col3_t;

  typedef struct packed {
    logic         func;
    col3_t [2:0]  el;
    logic [2:0]   ov;
    q16_t [2:0]   move;
  } mat_t;

  // arctangent of 2^-i in Q2.30
  function automatic cw_t atan_q30(logic [STEP_W-1:0] i);
    cw_t v;
    case (i)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  // product of two Q2.30 values, rounded half up
  function automatic rot_t mul30(q30_t a, q30_t b);
    logic signed [63:0] p;
    logic signed [63:0] s;
    p = a * b;
    p = p + 64'sd536870912;
    s = p >>> 30;
    return s[33:0];
  endfunction

endpackage

FILE: rtl/core/etmb_if.sv
// item and column channel interfaces
interface etmb_in_if;
  logic valid;
  logic ready;
  logic func;
  logic signed [15:0] rot_x;
  logic signed [15:0] rot_y;
  logic signed [15:0] rot_z;
  logic signed [31:0] scale_x;
  logic signed [31:0] scale_y;
  logic signed [31:0] scale_z;
  logic signed [31:0] move_x;
  logic signed [31:0] move_y;
  logic signed [31:0] move_z;
  modport source (output valid, func, rot_x, rot_y, rot_z, scale_x, scale_y, scale_z,
                  move_x, move_y, move_z, input ready);
  modport sink (input valid, func, rot_x, rot_y, rot_z, scale_x, scale_y, scale_z,
                move_x, move_y, move_z, output ready);
endinterface

interface etmb_out_if;
  logic valid;
  logic ready;
  logic [1:0] column;
  logic signed [31:0] elem_0;
  logic signed [31:0] elem_1;
  logic signed [31:0] elem_2;
  logic signed [31:0] elem_3;
  logic overflow;
  logic last;
  modport source (output valid, column, elem_0, elem_1, elem_2, elem_3, overflow, last,
                  input ready);
  modport sink (input valid, column, elem_0, elem_1, elem_2, elem_3, overflow, last,
                output ready);
endinterface

FILE: rtl/core/etmb_prep.sv
// angle range reduction and divider setup, two register stages
module etmb_prep (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  etmb_pkg::in_t  d_i,
  output logic           vld_o,
  output etmb_pkg::pipe_t d_o
);
  import etmb_pkg::*;

  pipe_t s1_d, s1_q, s2_d, s2_q;
  logic  v1_q, v2_q;

  // wrap angles into [-pi, pi], absolute scale and dividend
  always_comb begin
    ang_t r;
    logic [31:0] m;
    s1_d = '0;
    s1_d.func  = d_i.func;
    s1_d.scale = d_i.scale;
    s1_d.move  = d_i.move;
    for (int k = 0; k < 3; k++) begin
      r = ANG_W'(d_i.rot[k]) <<< ANG_SHIFT;
      if (r > PI) begin
        r = r - TWO_PI;
      end else if (r < NEG_PI) begin
        r = r + TWO_PI;
      end
      s1_d.cz[k] = r;
      m = d_i.scale[k][31] ? (~d_i.scale[k] + 32'd1) : d_i.scale[k];
      s1_d.dm[k]     = m;
      s1_d.s_neg[k]  = d_i.scale[k][31];
      s1_d.s_zero[k] = (d_i.scale[k] == '0);
      s1_d.dnum[k]   = (div_t'(1) << 32) + div_t'(m[31:1]);
    end
  end

  // fold into [-pi/2, pi/2] and seed the rotation
  always_comb begin
    ang_t r;
    s2_d = s1_q;
    for (int k = 0; k < 3; k++) begin
      r = s1_q.cz[k];
      s2_d.flip[k] = 1'b0;
      if (r > HALF_PI) begin
        r = PI - r;
        s2_d.flip[k] = 1'b1;
      end else if (r < NEG_HALF_PI) begin
        r = NEG_PI - r;
        s2_d.flip[k] = 1'b1;
      end
      s2_d.cz[k]   = r;
      s2_d.cx[k]   = GAIN;
      s2_d.cy[k]   = '0;
      s2_d.drem[k] = '0;
      s2_d.dquo[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  assign vld_o = v2_q;
  assign d_o   = s2_q;
endmodule

FILE: rtl/core/etmb_cordic_cell.sv
// one rotation step of the three sine/cosine lanes
module etmb_cordic_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [etmb_pkg::STEP_W-1:0] step_i,
  input  logic                        vld_i,
  input  etmb_pkg::pipe_t             d_i,
  output logic                        vld_o,
  output etmb_pkg::pipe_t             d_o
);
  import etmb_pkg::*;

  pipe_t nxt_d, cell_q;
  logic  vld_q;

  // micro-rotation towards zero residual angle
  always_comb begin
    cw_t  dx, dy;
    ang_t at;
    nxt_d = d_i;
    at = ANG_W'(atan_q30(step_i));
    for (int k = 0; k < 3; k++) begin
      dx = d_i.cy[k] >>> step_i;
      dy = d_i.cx[k] >>> step_i;
      if (!d_i.cz[k][ANG_W-1]) begin
        nxt_d.cx[k] = d_i.cx[k] - dx;
        nxt_d.cy[k] = d_i.cy[k] + dy;
        nxt_d.cz[k] = d_i.cz[k] - at;
      end else begin
        nxt_d.cx[k] = d_i.cx[k] + dx;
        nxt_d.cy[k] = d_i.cy[k] - dy;
        nxt_d.cz[k] = d_i.cz[k] + at;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= nxt_d;
    end
  end

  assign vld_o = vld_q;
  assign d_o   = cell_q;
endmodule

FILE: rtl/core/etmb_div_cell.sv
// one restoring division step of the three reciprocal lanes
module etmb_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  etmb_pkg::pipe_t d_i,
  output logic            vld_o,
  output etmb_pkg::pipe_t d_o
);
  import etmb_pkg::*;

  pipe_t nxt_d, cell_q;
  logic  vld_q;

  // shift in next dividend bit, subtract divisor when it fits
  always_comb begin
    div_t sh;
    div_t dv;
    nxt_d = d_i;
    for (int k = 0; k < 3; k++) begin
      sh = {d_i.drem[k][DIV_W-2:0], d_i.dnum[k][DIV_W-1]};
      dv = div_t'(d_i.dm[k]);
      nxt_d.dnum[k] = d_i.dnum[k] << 1;
      if (sh >= dv) begin
        nxt_d.drem[k] = sh - dv;
        nxt_d.dquo[k] = {d_i.dquo[k][DIV_W-2:0], 1'b1};
      end else begin
        nxt_d.drem[k] = sh;
        nxt_d.dquo[k] = {d_i.dquo[k][DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= nxt_d;
    end
  end

  assign vld_o = vld_q;
  assign d_o   = cell_q;
endmodule

FILE: rtl/core/etmb_matrix.sv
// rotation products, column scaling and saturation, five register stages
module etmb_matrix (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  etmb_pkg::pipe_t d_i,
  output logic            vld_o,
  output etmb_pkg::mat_t  d_o
);
  import etmb_pkg::*;

  typedef struct packed {
    logic       func;
    q16_t [2:0] f;
    logic [2:0] fov;
    q16_t [2:0] move;
  } side_t;

  localparam int P_S1S2 = 0;
  localparam int P_C1C3 = 1;
  localparam int P_C1S3 = 2;
  localparam int P_C2S3 = 3;
  localparam int P_C2C3 = 4;
  localparam int P_C2S1 = 5;
  localparam int P_C1C2 = 6;
  localparam int P_C3S1 = 7;
  localparam int P_S1S3 = 8;

  logic [4:0] vld_q;
  side_t a_side_d, a_side_q, b_side_q, c_side_q, d_side_q;
  rot_t  a_d [9];
  rot_t  a_q [9];
  q30_t  s2_a_q, s3_a_q, c3_a_q, s2_b_q;
  rot_t  b_d [4];
  rot_t  b_q [4];
  rot_t  pb_q [9];
  rot_t  c_d [3][3];
  rot_t  c_q [3][3];
  logic signed [65:0] p_q [3][3];
  mat_t  e_d, e_q;

  // stage a: sine/cosine pairs, first products, factor choice
  always_comb begin
    q30_t s1, c1, s2, c2, s3, c3;
    cw_t  nx;
    logic [DIV_W-1:0] q;
    nx = -d_i.cx[0];
    s1 = d_i.cy[0][31:0];
    c1 = d_i.flip[0] ? nx[31:0] : d_i.cx[0][31:0];
    nx = -d_i.cx[1];
    s2 = d_i.cy[1][31:0];
    c2 = d_i.flip[1] ? nx[31:0] : d_i.cx[1][31:0];
    nx = -d_i.cx[2];
    s3 = d_i.cy[2][31:0];
    c3 = d_i.flip[2] ? nx[31:0] : d_i.cx[2][31:0];
    a_d[P_S1S2] = mul30(s1, s2);
    a_d[P_C1C3] = mul30(c1, c3);
    a_d[P_C1S3] = mul30(c1, s3);
    a_d[P_C2S3] = mul30(c2, s3);
    a_d[P_C2C3] = mul30(c2, c3);
    a_d[P_C2S1] = mul30(c2, s1);
    a_d[P_C1C2] = mul30(c1, c2);
    a_d[P_C3S1] = mul30(c3, s1);
    a_d[P_S1S3] = mul30(s1, s3);
    a_side_d.func = d_i.func;
    a_side_d.move = d_i.move;
    for (int k = 0; k < 3; k++) begin
      q = d_i.dquo[k];
      a_side_d.f[k]   = d_i.scale[k];
      a_side_d.fov[k] = 1'b0;
      if (d_i.func) begin
        if (d_i.s_zero[k]) begin
          a_side_d.f[k]   = Q16_MAX;
          a_side_d.fov[k] = 1'b1;
        end else if (!d_i.s_neg[k]) begin
          if (q > DIV_W'(33'h0_7fff_ffff)) begin
            a_side_d.f[k]   = Q16_MAX;
            a_side_d.fov[k] = 1'b1;
          end else begin
            a_side_d.f[k] = q[31:0];
          end
        end else begin
          if (q > DIV_W'(33'h0_8000_0000)) begin
            a_side_d.f[k]   = Q16_MIN;
            a_side_d.fov[k] = 1'b1;
          end else begin
            a_side_d.f[k] = ~q[31:0] + 32'd1;
          end
        end
      end
    end
  end

  // stage b: triple products
  always_comb begin
    b_d[0] = mul30(a_q[P_S1S2][31:0], s3_a_q);
    b_d[1] = mul30(a_q[P_C1S3][31:0], s2_a_q);
    b_d[2] = mul30(c3_a_q, a_q[P_S1S2][31:0]);
    b_d[3] = mul30(a_q[P_C1C3][31:0], s2_a_q);
  end

  // stage c: rotation entries, indexed column then row
  always_comb begin
    c_d[0][0] = pb_q[P_C1C3] + b_q[0];
    c_d[0][1] = pb_q[P_C2S3];
    c_d[0][2] = b_q[1] - pb_q[P_C3S1];
    c_d[1][0] = b_q[2] - pb_q[P_C1S3];
    c_d[1][1] = pb_q[P_C2C3];
    c_d[1][2] = b_q[3] + pb_q[P_S1S3];
    c_d[2][0] = pb_q[P_C2S1];
    c_d[2][1] = -rot_t'(s2_b_q);
    c_d[2][2] = pb_q[P_C1C2];
  end

  // stage e: round half up and saturate each element
  always_comb begin
    logic signed [65:0] t;
    e_d.func = d_side_q.func;
    e_d.move = d_side_q.move;
    for (int c = 0; c < 3; c++) begin
      e_d.ov[c] = d_side_q.fov[c];
      for (int r = 0; r < 3; r++) begin
        t = (p_q[c][r] + 66'sd536870912) >>> 30;
        if (t > 66'(Q16_MAX)) begin
          e_d.el[c][r] = Q16_MAX;
          e_d.ov[c]    = 1'b1;
        end else if (t < 66'(Q16_MIN)) begin
          e_d.el[c][r] = Q16_MIN;
          e_d.ov[c]    = 1'b1;
        end else begin
          e_d.el[c][r] = t[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q      <= a_d;
      s2_a_q   <= d_i.cy[1][31:0];
      s3_a_q   <= d_i.cy[2][31:0];
      c3_a_q   <= d_i.flip[2] ? 32'(-d_i.cx[2]) : d_i.cx[2][31:0];
      a_side_q <= a_side_d;
      b_q      <= b_d;
      pb_q     <= a_q;
      s2_b_q   <= s2_a_q;
      b_side_q <= a_side_q;
      c_q      <= c_d;
      c_side_q <= b_side_q;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          p_q[c][r] <= c_side_q.f[c] * c_q[c][r];
        end
      end
      d_side_q <= c_side_q;
      e_q      <= e_d;
    end
  end

  assign vld_o = vld_q[4];
  assign d_o   = e_q;
endmodule

FILE: rtl/core/euler_trs_matrix_builder_top.sv
// top level: euler y-x-z transform matrix builder
// path from input transfer to first column: prep registers, sine/cosine cells,
//   reciprocal cells, matrix stages and the column output register
// throughput: one column per cycle while out_o.ready is high; a model matrix gives
//   four columns and a normal matrix three, each held in the column output register
// reset clears only the valid bits and the column counter, no payload
module euler_trs_matrix_builder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  etmb_in_if.sink     in_i,
  etmb_out_if.source  out_o
);
  import etmb_pkg::*;

  in_t   in_d;
  logic  en;
  logic  cvld [CORDIC_STEPS+1];
  pipe_t cpipe [CORDIC_STEPS+1];
  logic  dvld [DIV_W+1];
  pipe_t dpipe [DIV_W+1];
  logic  mat_vld;
  mat_t  mat;
  mat_t  buf_q;
  logic  buf_vld_q;
  logic [1:0] col_q;
  logic [1:0] last_col;

  // item payload, rotation lanes ordered y, x, z, scale and move lanes x, y, z
  always_comb begin
    in_d.func     = in_i.func;
    in_d.rot[0]   = in_i.rot_y;
    in_d.rot[1]   = in_i.rot_x;
    in_d.rot[2]   = in_i.rot_z;
    in_d.scale[0] = in_i.scale_x;
    in_d.scale[1] = in_i.scale_y;
    in_d.scale[2] = in_i.scale_z;
    in_d.move[0]  = in_i.move_x;
    in_d.move[1]  = in_i.move_y;
    in_d.move[2]  = in_i.move_z;
  end

  // whole chain moves when the column register frees up
  assign last_col   = buf_q.func ? COL_LAST_NORMAL : COL_MOVE;
  assign en         = !buf_vld_q || (out_o.ready && col_q == last_col);
  assign in_i.ready = en;

  etmb_prep u_prep (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_i.valid), .d_i(in_d),
    .vld_o(cvld[0]), .d_o(cpipe[0])
  );

  // sine/cosine cells
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    etmb_cordic_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .step_i(STEP_W'(i)),
      .vld_i(cvld[i]), .d_i(cpipe[i]), .vld_o(cvld[i+1]), .d_o(cpipe[i+1])
    );
  end

  assign dvld[0]  = cvld[CORDIC_STEPS];
  assign dpipe[0] = cpipe[CORDIC_STEPS];

  // reciprocal cells
  for (genvar i = 0; i < DIV_W; i++) begin : g_div
    etmb_div_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(dvld[i]), .d_i(dpipe[i]), .vld_o(dvld[i+1]), .d_o(dpipe[i+1])
    );
  end

  etmb_matrix u_matrix (
    .clk_i, .rst_ni, .en_i(en), .vld_i(dvld[DIV_W]), .d_i(dpipe[DIV_W]),
    .vld_o(mat_vld), .d_o(mat)
  );

  // column register and column counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_vld_q <= 1'b0;
      col_q     <= '0;
    end else if (en) begin
      buf_vld_q <= mat_vld;
      col_q     <= '0;
    end else if (out_o.ready) begin
      col_q <= col_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      buf_q <= mat;
    end
  end

  // column select
  always_comb begin
    out_o.valid  = buf_vld_q;
    out_o.column = col_q;
    out_o.last   = (col_q == last_col);
    case (col_q)
      COL_MOVE: begin
        out_o.elem_0   = buf_q.move[0];
        out_o.elem_1   = buf_q.move[1];
        out_o.elem_2   = buf_q.move[2];
        out_o.elem_3   = ONE_Q16;
        out_o.overflow = 1'b0;
      end
      default: begin
        out_o.elem_0   = buf_q.el[col_q][0];
        out_o.elem_1   = buf_q.el[col_q][1];
        out_o.elem_2   = buf_q.el[col_q][2];
        out_o.elem_3   = '0;
        out_o.overflow = buf_q.ov[col_q];
      end
    endcase
  end
endmodule

FILE: rtl/core/etmb_checker.sv
// port-level checks of the column channel, bound to the top level
module etmb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  column,
  input logic [31:0] elem_3,
  input logic        overflow,
  input logic        last
);
  // stalled column holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(column) && $stable(last))
    else $error("stalled column changed");

  // columns of one item come in order
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !last |=> out_valid && column == $past(column) + 2'd1)
    else $error("column sequence broken");

  // a new item starts at column zero
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && last) ##1 out_valid |-> column == 2'd0)
    else $error("item does not start at column zero");

  // last only on column two or three
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && last |-> column == 2'd2 || column == 2'd3)
    else $error("last on wrong column");

  // bottom row of every column and flag of the translation column
  a_row3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (column == 2'd3) ? (elem_3 == 32'h0001_0000 && !overflow)
                                   : (elem_3 == 32'h0))
    else $error("bottom row wrong");
endmodule

bind euler_trs_matrix_builder_top etmb_checker u_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .column    (out_o.column),
  .elem_3    (out_o.elem_3),
  .overflow  (out_o.overflow),
  .last      (out_o.last)
);

FILE: bench/etmb_matrix_checker.sv
// column checker: predicts transform matrix columns and compares transfers
`timescale 1ns / 100ps
module etmb_matrix_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  etmb_in_if         in_i,
  etmb_out_if        out_o,
  output int         fail_cnt_o,
  output int         pending_o
);
  import etmb_pkg::*;

  typedef struct {
    logic [1:0]  column;
    logic [31:0] e0, e1, e2, e3;
    logic        overflow;
    logic        last;
  } column_t;

  column_t col_q[$];
  int      fails;

  localparam longint ATAN_TAB [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128};

  assign fail_cnt_o = fails;
  assign pending_o  = col_q.size();

  // floor shift, matches an arithmetic shift on a longint
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rmul(longint a, longint b);
    return asr(a * b + 64'sd536870912, 30);
  endfunction

  function automatic longint clip32(longint v, ref logic ov);
    if (v > 64'sd2147483647) begin
      ov = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // range reduced rotation-mode cordic
  task automatic angle_sin_cos(input logic signed [15:0] ang, output longint sn,
                               output longint cs);
    longint r, x, y, z, dx, dy;
    logic   flip;
    r = longint'(ang) * 262144;
    flip = 1'b0;
    if (r > 64'sd3373259426) r -= 64'sd6746518852;
    if (r < -64'sd3373259426) r += 64'sd6746518852;
    if (r > 64'sd1686629713) begin
      r = 64'sd3373259426 - r;
      flip = 1'b1;
    end else if (r < -64'sd1686629713) begin
      r = -64'sd3373259426 - r;
      flip = 1'b1;
    end
    x = 64'sd652032874;
    y = 0;
    z = r;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    sn = y;
    cs = flip ? -x : x;
  endtask

  function automatic longint inverse_scale(longint s, ref logic ov);
    longint m, q;
    if (s == 0) begin
      ov = 1'b1;
      return 64'sd2147483647;
    end
    m = (s < 0) ? -s : s;
    q = ((64'sd1 << 32) + m / 2) / m;
    return clip32((s < 0) ? -q : q, ov);
  endfunction

  // builds the expected columns of one item
  task automatic predict_matrix();
    longint s1, c1, s2, c2, s3, c3, s1s2, c1c3, c1s3, f;
    longint rm [3][3];
    longint sc [3];
    logic   ov;
    column_t c;
    angle_sin_cos(in_i.rot_y, s1, c1);
    angle_sin_cos(in_i.rot_x, s2, c2);
    angle_sin_cos(in_i.rot_z, s3, c3);
    s1s2 = rmul(s1, s2);
    c1c3 = rmul(c1, c3);
    c1s3 = rmul(c1, s3);
    rm[0][0] = c1c3 + rmul(s1s2, s3);
    rm[0][1] = rmul(c2, s3);
    rm[0][2] = rmul(c1s3, s2) - rmul(c3, s1);
    rm[1][0] = rmul(c3, s1s2) - c1s3;
    rm[1][1] = rmul(c2, c3);
    rm[1][2] = rmul(c1c3, s2) + rmul(s1, s3);
    rm[2][0] = rmul(c2, s1);
    rm[2][1] = -s2;
    rm[2][2] = rmul(c1, c2);
    sc[0] = in_i.scale_x;
    sc[1] = in_i.scale_y;
    sc[2] = in_i.scale_z;
    for (int k = 0; k < 3; k++) begin
      ov = 1'b0;
      f = in_i.func ? inverse_scale(sc[k], ov) : sc[k];
      c.column = 2'(k);
      c.e0 = 32'(clip32(asr(f * rm[k][0] + 64'sd536870912, 30), ov));
      c.e1 = 32'(clip32(asr(f * rm[k][1] + 64'sd536870912, 30), ov));
      c.e2 = 32'(clip32(asr(f * rm[k][2] + 64'sd536870912, 30), ov));
      c.e3 = '0;
      c.overflow = ov;
      c.last = in_i.func && (2'(k) == COL_LAST_NORMAL);
      col_q.push_back(c);
    end
    if (!in_i.func) begin
      c.column = COL_MOVE;
      c.e0 = in_i.move_x;
      c.e1 = in_i.move_y;
      c.e2 = in_i.move_z;
      c.e3 = ONE_Q16;
      c.overflow = 1'b0;
      c.last = 1'b1;
      col_q.push_back(c);
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fails++;
    end
  endtask

  // watch both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    column_t e;
    if (!rst_ni) begin
      fails = 0;
    end else begin
      if (in_i.valid && in_i.ready) predict_matrix();
      if (out_o.valid && out_o.ready) begin
        if (col_q.size() == 0) begin
          $error("column transfer with no expected column");
          fails++;
        end else begin
          e = col_q.pop_front();
          check_field("column", e.column, out_o.column);
          check_field("elem_0", e.e0, out_o.elem_0);
          check_field("elem_1", e.e1, out_o.elem_1);
          check_field("elem_2", e.e2, out_o.elem_2);
          check_field("elem_3", e.e3, out_o.elem_3);
          check_field("overflow", e.overflow, out_o.overflow);
          check_field("last", e.last, out_o.last);
        end
      end
    end
  end
endmodule

FILE: bench/euler_trs_matrix_builder_top_test.sv
// testbench top: stimulus, idling and verdict for the transform matrix builder
`timescale 1ns / 100ps
module euler_trs_matrix_builder_top_test;
  import etmb_pkg::*;

  localparam int  N_RANDOM = 320;
  localparam longint CYCLE_LIMIT = 200000;

  logic   clk_i;
  logic   rst_ni;
  int     fail_cnt;
  int     pending;
  longint cycles;
  bit     calm;
  int     n_items;

  etmb_in_if  in_if ();
  etmb_out_if out_if ();

  euler_trs_matrix_builder_top dut (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_i (in_if.sink), .out_o (out_if.source)
  );

  etmb_matrix_checker checker_u (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_i (in_if), .out_o (out_if),
    .fail_cnt_o (fail_cnt), .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver stalls
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= calm || ($urandom_range(99) >= 13);
    end
  end

  function automatic logic [31:0] rnd_q16();
    case ($urandom_range(5))
      0: return 32'($urandom_range(3)) - 32'd1;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed(16'($urandom)));
      3: return $urandom_range(1) ? 32'h00010000 : 32'hffff0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic fn, logic [15:0] rx, logic [15:0] ry, logic [15:0] rz,
                           logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                           logic [31:0] mx, logic [31:0] my, logic [31:0] mz);
    while (!calm && $urandom_range(99) < 13) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.func    <= fn;
    in_if.rot_x   <= rx;
    in_if.rot_y   <= ry;
    in_if.rot_z   <= rz;
    in_if.scale_x <= sx;
    in_if.scale_y <= sy;
    in_if.scale_z <= sz;
    in_if.move_x  <= mx;
    in_if.move_y  <= my;
    in_if.move_z  <= mz;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    n_items++;
  endtask

  initial begin
    logic [15:0] angs [8];
    int wait_cnt;
    angs = '{16'h0000, 16'h7fff, 16'h8000, 16'h1922, 16'he6de, 16'h3244, 16'hcdbc,
             16'h6488};
    calm = 1'b0;
    n_items = 0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    {in_if.func, in_if.rot_x, in_if.rot_y, in_if.rot_z} = '0;
    {in_if.scale_x, in_if.scale_y, in_if.scale_z} = '0;
    {in_if.move_x, in_if.move_y, in_if.move_z} = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: angle extremes, quadrant folds, unit and extreme scales, zero and tiny scales
    for (int i = 0; i < 8; i++)
      send_item(i[0], angs[i], angs[7 - i], angs[(i + 3) % 8], ONE_Q16, Q16_MAX, Q16_MIN,
                Q16_MAX, Q16_MIN, 32'h0);
    send_item(1'b1, 16'h0, 16'h0, 16'h0, 32'h0, 32'h1, 32'hffffffff, '0, '0, '0);
    send_item(1'b1, 16'h1000, 16'hf000, 16'h0800, 32'h2, 32'hfffffffe, 32'h3, '0, '0, '0);
    send_item(1'b1, 16'h7fff, 16'h8000, 16'h1234, Q16_MAX, Q16_MIN, ONE_Q16, '0, '0, '0);
    send_item(1'b0, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 32'hffffffff, 32'h1, ONE_Q16);
    send_item(1'b0, 16'h0c90, 16'h0c90, 16'h0c90, 32'h00020000, 32'hfffe0000, 32'h00008000,
              32'h12345678, 32'h9abcdef0, 32'h7fffffff);

    // random: a calm stretch in the middle
    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 120 && i < 180);
      send_item(1'($urandom_range(1)), 16'($urandom), 16'($urandom), 16'($urandom),
                rnd_q16(), rnd_q16(), rnd_q16(), $urandom, $urandom, rnd_q16());
    end
    calm = 1'b0;
    in_if.valid <= 1'b0;

    // drain, then a short settle
    while (pending != 0) @(posedge clk_i);
    wait_cnt = 0;
    while (wait_cnt < 100) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    $display("covered %0d items in both matrix modes, with angle folds, zero and extreme scales",
             n_items);
    if (fail_cnt == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/etmb_pkg.sv
rtl/core/etmb_if.sv
rtl/core/etmb_prep.sv
rtl/core/etmb_cordic_cell.sv
rtl/core/etmb_div_cell.sv
rtl/core/etmb_matrix.sv
rtl/core/euler_trs_matrix_builder_top.sv
rtl/core/etmb_checker.sv
bench/etmb_matrix_checker.sv
bench/euler_trs_matrix_builder_top_test.sv
